/* sv/pthc_pkg.sv */
// Shared types, operation codes and the compensation microcode for the
// pressure/temperature/humidity compensation block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pthc_pkg;

    localparam int unsigned PC_W   = 7;
    localparam int unsigned ROM_DEPTH = 82;

    // input kinds
    localparam logic [1:0] FUNC_TEMP  = 2'd0;
    localparam logic [1:0] FUNC_PRESS = 2'd1;
    localparam logic [1:0] FUNC_HUM   = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_TEMP    = 3'd0;
    localparam logic [2:0] CFG_PRESS_A = 3'd1;
    localparam logic [2:0] CFG_PRESS_B = 3'd2;
    localparam logic [2:0] CFG_PRESS_C = 3'd3;
    localparam logic [2:0] CFG_HUM_A   = 3'd4;
    localparam logic [2:0] CFG_HUM_B   = 3'd5;

    // micro-ops
    localparam logic [3:0] OP_ADD   = 4'd0;
    localparam logic [3:0] OP_SUB   = 4'd1;
    localparam logic [3:0] OP_MUL   = 4'd2;
    localparam logic [3:0] OP_SHL   = 4'd3;
    localparam logic [3:0] OP_ASR   = 4'd4;
    localparam logic [3:0] OP_DIV   = 4'd5;
    localparam logic [3:0] OP_SETFT = 4'd6;
    localparam logic [3:0] OP_ZCHK  = 4'd7;
    localparam logic [3:0] OP_CLAMP = 4'd8;
    localparam logic [3:0] OP_END   = 4'd9;

    // destination registers
    localparam logic [1:0] D0 = 2'd0;
    localparam logic [1:0] D1 = 2'd1;
    localparam logic [1:0] D2 = 2'd2;
    localparam logic [1:0] D3 = 2'd3;

    // operand sources
    localparam logic [4:0] S_R0    = 5'd0;
    localparam logic [4:0] S_R1    = 5'd1;
    localparam logic [4:0] S_R2    = 5'd2;
    localparam logic [4:0] S_R3    = 5'd3;
    localparam logic [4:0] S_ADC   = 5'd4;
    localparam logic [4:0] S_ADC16 = 5'd5;
    localparam logic [4:0] S_FT    = 5'd6;
    localparam logic [4:0] S_IMM   = 5'd7;
    localparam logic [4:0] S_T1    = 5'd8;
    localparam logic [4:0] S_T2    = 5'd9;
    localparam logic [4:0] S_T3    = 5'd10;
    localparam logic [4:0] S_P1    = 5'd11;
    localparam logic [4:0] S_P2    = 5'd12;
    localparam logic [4:0] S_P3    = 5'd13;
    localparam logic [4:0] S_P4    = 5'd14;
    localparam logic [4:0] S_P5    = 5'd15;
    localparam logic [4:0] S_P6    = 5'd16;
    localparam logic [4:0] S_P7    = 5'd17;
    localparam logic [4:0] S_P8    = 5'd18;
    localparam logic [4:0] S_P9    = 5'd19;
    localparam logic [4:0] S_H1    = 5'd20;
    localparam logic [4:0] S_H2    = 5'd21;
    localparam logic [4:0] S_H3    = 5'd22;
    localparam logic [4:0] S_H4    = 5'd23;
    localparam logic [4:0] S_H5    = 5'd24;
    localparam logic [4:0] S_H6    = 5'd25;

    localparam logic [PC_W-1:0] PC_TEMP  = 7'd0;
    localparam logic [PC_W-1:0] PC_PRESS = 7'd17;
    localparam logic [PC_W-1:0] PC_HUM   = 7'd52;
    localparam logic [PC_W-1:0] PC_NONE  = 7'd81;

    localparam logic [63:0] HUM_MAX = 64'd419430400;

    typedef struct packed {
        logic [3:0]         op;
        logic [1:0]         dst;
        logic [4:0]         a;
        logic [4:0]         b;
        logic [5:0]         sh;
        logic               w32;   // wrap result to 32 bits, sign-extended
        logic signed [31:0] imm;
    } instr_t;

    function automatic logic [63:0] sext32(input logic [31:0] x);
        return {{32{x[31]}}, x};
    endfunction

    function automatic instr_t mk(input logic [3:0] op, input logic [1:0] dst,
                                  input logic [4:0] a, input logic [4:0] b,
                                  input logic [5:0] sh, input logic w32,
                                  input logic signed [31:0] imm);
        instr_t r;
        r.op  = op;
        r.dst = dst;
        r.a   = a;
        r.b   = b;
        r.sh  = sh;
        r.w32 = w32;
        r.imm = imm;
        return r;
    endfunction

    function automatic logic [PC_W-1:0] start_pc(input logic [1:0] func);
        logic [PC_W-1:0] r;
        case (func)
            FUNC_TEMP:  r = PC_TEMP;
            FUNC_PRESS: r = PC_PRESS;
            FUNC_HUM:   r = PC_HUM;
            default:    r = PC_NONE;
        endcase
        return r;
    endfunction

    function automatic instr_t rom(input logic [PC_W-1:0] pc);
        instr_t r;
        case (pc)
            // temperature, 32-bit wrap
            7'd0:  r = mk(OP_ASR,  D0, S_ADC, S_R0,  6'd3,  1'b1, 32'sd0);
            7'd1:  r = mk(OP_SHL,  D1, S_T1,  S_R0,  6'd1,  1'b1, 32'sd0);
            7'd2:  r = mk(OP_SUB,  D0, S_R0,  S_R1,  6'd0,  1'b1, 32'sd0);
            7'd3:  r = mk(OP_MUL,  D0, S_R0,  S_T2,  6'd0,  1'b1, 32'sd0);
            7'd4:  r = mk(OP_ASR,  D0, S_R0,  S_R0,  6'd11, 1'b1, 32'sd0);
            7'd5:  r = mk(OP_ASR,  D1, S_ADC, S_R0,  6'd4,  1'b1, 32'sd0);
            7'd6:  r = mk(OP_SUB,  D1, S_R1,  S_T1,  6'd0,  1'b1, 32'sd0);
            7'd7:  r = mk(OP_MUL,  D1, S_R1,  S_R1,  6'd0,  1'b1, 32'sd0);
            7'd8:  r = mk(OP_ASR,  D1, S_R1,  S_R0,  6'd12, 1'b1, 32'sd0);
            7'd9:  r = mk(OP_MUL,  D1, S_R1,  S_T3,  6'd0,  1'b1, 32'sd0);
            7'd10: r = mk(OP_ASR,  D1, S_R1,  S_R0,  6'd14, 1'b1, 32'sd0);
            7'd11: r = mk(OP_ADD,  D0, S_R0,  S_R1,  6'd0,  1'b1, 32'sd0);
            7'd12: r = mk(OP_SETFT, D0, S_R0, S_R0,  6'd0,  1'b1, 32'sd0);
            7'd13: r = mk(OP_MUL,  D0, S_R0,  S_IMM, 6'd0,  1'b1, 32'sd5);
            7'd14: r = mk(OP_ADD,  D0, S_R0,  S_IMM, 6'd0,  1'b1, 32'sd128);
            7'd15: r = mk(OP_ASR,  D0, S_R0,  S_R0,  6'd8,  1'b1, 32'sd0);
            7'd16: r = mk(OP_END,  D0, S_R0,  S_R0,  6'd0,  1'b1, 32'sd0);
            // pressure, 64-bit wrap
            7'd17: r = mk(OP_SUB,  D0, S_FT,  S_IMM, 6'd0,  1'b0, 32'sd128000);
            7'd18: r = mk(OP_MUL,  D1, S_R0,  S_R0,  6'd0,  1'b0, 32'sd0);
            7'd19: r = mk(OP_MUL,  D2, S_R1,  S_P6,  6'd0,  1'b0, 32'sd0);
            7'd20: r = mk(OP_MUL,  D3, S_R0,  S_P5,  6'd0,  1'b0, 32'sd0);
            7'd21: r = mk(OP_SHL,  D3, S_R3,  S_R0,  6'd17, 1'b0, 32'sd0);
            7'd22: r = mk(OP_ADD,  D2, S_R2,  S_R3,  6'd0,  1'b0, 32'sd0);
            7'd23: r = mk(OP_SHL,  D3, S_P4,  S_R0,  6'd35, 1'b0, 32'sd0);
            7'd24: r = mk(OP_ADD,  D2, S_R2,  S_R3,  6'd0,  1'b0, 32'sd0);
            7'd25: r = mk(OP_MUL,  D1, S_R1,  S_P3,  6'd0,  1'b0, 32'sd0);
            7'd26: r = mk(OP_ASR,  D1, S_R1,  S_R0,  6'd8,  1'b0, 32'sd0);
            7'd27: r = mk(OP_MUL,  D3, S_R0,  S_P2,  6'd0,  1'b0, 32'sd0);
            7'd28: r = mk(OP_SHL,  D3, S_R3,  S_R0,  6'd12, 1'b0, 32'sd0);
            7'd29: r = mk(OP_ADD,  D0, S_R1,  S_R3,  6'd0,  1'b0, 32'sd0);
            7'd30: r = mk(OP_SHL,  D1, S_IMM, S_R0,  6'd47, 1'b0, 32'sd1);
            7'd31: r = mk(OP_ADD,  D0, S_R1,  S_R0,  6'd0,  1'b0, 32'sd0);
            7'd32: r = mk(OP_MUL,  D0, S_R0,  S_P1,  6'd0,  1'b0, 32'sd0);
            7'd33: r = mk(OP_ASR,  D0, S_R0,  S_R0,  6'd33, 1'b0, 32'sd0);
            7'd34: r = mk(OP_ZCHK, D0, S_R0,  S_R0,  6'd0,  1'b0, 32'sd0);
            7'd35: r = mk(OP_SUB,  D1, S_IMM, S_ADC, 6'd0,  1'b0, 32'sd1048576);
            7'd36: r = mk(OP_SHL,  D1, S_R1,  S_R0,  6'd31, 1'b0, 32'sd0);
            7'd37: r = mk(OP_SUB,  D1, S_R1,  S_R2,  6'd0,  1'b0, 32'sd0);
            7'd38: r = mk(OP_MUL,  D1, S_R1,  S_IMM, 6'd0,  1'b0, 32'sd3125);
            7'd39: r = mk(OP_DIV,  D1, S_R1,  S_R0,  6'd0,  1'b0, 32'sd0);
            7'd40: r = mk(OP_ASR,  D2, S_R1,  S_R0,  6'd13, 1'b0, 32'sd0);
            7'd41: r = mk(OP_MUL,  D3, S_R2,  S_R2,  6'd0,  1'b0, 32'sd0);
            7'd42: r = mk(OP_MUL,  D3, S_R3,  S_P9,  6'd0,  1'b0, 32'sd0);
            7'd43: r = mk(OP_ASR,  D3, S_R3,  S_R0,  6'd25, 1'b0, 32'sd0);
            7'd44: r = mk(OP_MUL,  D2, S_R1,  S_P8,  6'd0,  1'b0, 32'sd0);
            7'd45: r = mk(OP_ASR,  D2, S_R2,  S_R0,  6'd19, 1'b0, 32'sd0);
            7'd46: r = mk(OP_ADD,  D1, S_R1,  S_R3,  6'd0,  1'b0, 32'sd0);
            7'd47: r = mk(OP_ADD,  D1, S_R1,  S_R2,  6'd0,  1'b0, 32'sd0);
            7'd48: r = mk(OP_ASR,  D1, S_R1,  S_R0,  6'd8,  1'b0, 32'sd0);
            7'd49: r = mk(OP_SHL,  D2, S_P7,  S_R0,  6'd4,  1'b0, 32'sd0);
            7'd50: r = mk(OP_ADD,  D1, S_R1,  S_R2,  6'd0,  1'b0, 32'sd0);
            7'd51: r = mk(OP_END,  D1, S_R1,  S_R0,  6'd0,  1'b0, 32'sd0);
            // humidity, 32-bit wrap
            7'd52: r = mk(OP_SUB,  D0, S_FT,  S_IMM, 6'd0,  1'b1, 32'sd76800);
            7'd53: r = mk(OP_SHL,  D1, S_ADC16, S_R0, 6'd14, 1'b1, 32'sd0);
            7'd54: r = mk(OP_SHL,  D2, S_H4,  S_R0,  6'd20, 1'b1, 32'sd0);
            7'd55: r = mk(OP_SUB,  D1, S_R1,  S_R2,  6'd0,  1'b1, 32'sd0);
            7'd56: r = mk(OP_MUL,  D2, S_H5,  S_R0,  6'd0,  1'b1, 32'sd0);
            7'd57: r = mk(OP_SUB,  D1, S_R1,  S_R2,  6'd0,  1'b1, 32'sd0);
            7'd58: r = mk(OP_ADD,  D1, S_R1,  S_IMM, 6'd0,  1'b1, 32'sd16384);
            7'd59: r = mk(OP_ASR,  D1, S_R1,  S_R0,  6'd15, 1'b1, 32'sd0);
            7'd60: r = mk(OP_MUL,  D2, S_R0,  S_H6,  6'd0,  1'b1, 32'sd0);
            7'd61: r = mk(OP_ASR,  D2, S_R2,  S_R0,  6'd10, 1'b1, 32'sd0);
            7'd62: r = mk(OP_MUL,  D3, S_R0,  S_H3,  6'd0,  1'b1, 32'sd0);
            7'd63: r = mk(OP_ASR,  D3, S_R3,  S_R0,  6'd11, 1'b1, 32'sd0);
            7'd64: r = mk(OP_ADD,  D3, S_R3,  S_IMM, 6'd0,  1'b1, 32'sd32768);
            7'd65: r = mk(OP_MUL,  D2, S_R2,  S_R3,  6'd0,  1'b1, 32'sd0);
            7'd66: r = mk(OP_ASR,  D2, S_R2,  S_R0,  6'd10, 1'b1, 32'sd0);
            7'd67: r = mk(OP_ADD,  D2, S_R2,  S_IMM, 6'd0,  1'b1, 32'sd2097152);
            7'd68: r = mk(OP_MUL,  D2, S_R2,  S_H2,  6'd0,  1'b1, 32'sd0);
            7'd69: r = mk(OP_ADD,  D2, S_R2,  S_IMM, 6'd0,  1'b1, 32'sd8192);
            7'd70: r = mk(OP_ASR,  D2, S_R2,  S_R0,  6'd14, 1'b1, 32'sd0);
            7'd71: r = mk(OP_MUL,  D0, S_R1,  S_R2,  6'd0,  1'b1, 32'sd0);
            7'd72: r = mk(OP_ASR,  D1, S_R0,  S_R0,  6'd15, 1'b1, 32'sd0);
            7'd73: r = mk(OP_MUL,  D1, S_R1,  S_R1,  6'd0,  1'b1, 32'sd0);
            7'd74: r = mk(OP_ASR,  D1, S_R1,  S_R0,  6'd7,  1'b1, 32'sd0);
            7'd75: r = mk(OP_MUL,  D1, S_R1,  S_H1,  6'd0,  1'b1, 32'sd0);
            7'd76: r = mk(OP_ASR,  D1, S_R1,  S_R0,  6'd4,  1'b1, 32'sd0);
            7'd77: r = mk(OP_SUB,  D0, S_R0,  S_R1,  6'd0,  1'b1, 32'sd0);
            7'd78: r = mk(OP_CLAMP, D0, S_R0, S_R0,  6'd0,  1'b1, 32'sd0);
            7'd79: r = mk(OP_ASR,  D0, S_R0,  S_R0,  6'd12, 1'b1, 32'sd0);
            7'd80: r = mk(OP_END,  D0, S_R0,  S_R0,  6'd0,  1'b1, 32'sd0);
            // unused kind: result 0
            default: r = mk(OP_END, D0, S_IMM, S_R0, 6'd0,  1'b0, 32'sd0);
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* sv/pthc_mul.sv */
// 64 x 64 multiplier, product modulo 2^64, built from one 32 x 32 multiplier
// used in turn for up to three partial products. Standalone; no package use.
`timescale 1ns / 1ps
`default_nettype none

module pthc_mul (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        w32,      // only the low 32 product bits are needed
    input  wire logic [63:0] a,
    input  wire logic [63:0] b,
    output logic             done,
    output logic [63:0]      p
);

    logic        busy_reg;
    logic [1:0]  cnt_reg;
    logic        done_reg;
    logic        w_reg;
    logic [63:0] a_reg;
    logic [63:0] b_reg;
    logic [63:0] prod_reg;
    logic [63:0] acc_reg;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;

    // lo*lo, then lo*hi, then hi*lo
    assign mul_a = (cnt_reg == 2'd2) ? a_reg[63:32] : a_reg[31:0];
    assign mul_b = (cnt_reg == 2'd1) ? b_reg[63:32] : b_reg[31:0];
    assign mul_p = mul_a * mul_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 2'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 2'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 2'd1;
                if ((cnt_reg == 2'd3) || ((cnt_reg == 2'd1) && w_reg))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
            w_reg <= w32;
        end
        else if (busy_reg)
        begin
            prod_reg <= mul_p;
            case (cnt_reg)
                2'd0:    acc_reg <= acc_reg;
                2'd1:    acc_reg <= prod_reg;
                default: acc_reg[63:32] <= acc_reg[63:32] + prod_reg[31:0];
            endcase
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule

`default_nettype wire

/* sv/pthc_div.sv */
// Signed 64-bit divider, one quotient bit per cycle (restoring), quotient
// truncated toward zero. Divisor must be nonzero. Standalone.
`timescale 1ns / 1ps
`default_nettype none

module pthc_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] n,
    input  wire logic [63:0] d,
    output logic             done,
    output logic [63:0]      q
);

    logic        busy_reg;
    logic [5:0]  cnt_reg;
    logic        done_reg;
    logic        neg_reg;
    logic [63:0] md_reg;
    logic [63:0] rem_reg;
    logic [63:0] q_reg;
    logic [64:0] rem_sh;
    logic [64:0] diff;

    assign rem_sh = {rem_reg, q_reg[63]};
    assign diff   = rem_sh - {1'b0, md_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 6'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            // the most negative value maps onto itself, read as unsigned 2^63
            q_reg   <= n[63] ? (64'd0 - n) : n;
            md_reg  <= d[63] ? (64'd0 - d) : d;
            neg_reg <= n[63] ^ d[63];
            rem_reg <= 64'd0;
        end
        else if (busy_reg)
        begin
            if (!diff[64])
            begin
                rem_reg <= diff[63:0];
                q_reg   <= {q_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[63:0];
                q_reg   <= {q_reg[62:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign q    = neg_reg ? (64'd0 - q_reg) : q_reg;

endmodule

`default_nettype wire

/* sv/pth_sensor_compensation.sv */
// Top level of the sensor compensation block: microcode sequencer, register
// file, ALU and output register. Uses pthc_pkg, pthc_mul and pthc_div.
`timescale 1ns / 1ps
`default_nettype none

// One raw reading is taken at a time and runs a short microcode program on a
// shared 64-bit ALU, a 32x32 multiplier stepped over up to three partial
// products and a one-bit-per-cycle divider. Each op passes through an operand
// read state and an execute state; a multiply or divide then waits for its
// unit. The result goes into the output register once that is free. Input is
// ready only while the sequencer is idle; a finished result waiting at the
// output does not stop the next item from being taken. Pressure and humidity
// use the fine temperature left by the last temperature item (zero after
// reset).

module pth_sensor_compensation (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // [19:0] raw_reading, [23:20] zero
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] func
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] compensated_value
    output logic [2:0]       m_axis_tuser,   // [1:0] reading_kind, [2] zero_divisor
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [47:0] cfg_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FETCH = 3'd1;
    localparam logic [2:0] ST_EXEC  = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]  state_reg;
    logic [pthc_pkg::PC_W-1:0] pc_reg;
    logic [31:0] ft_reg;
    logic        m_valid_reg;

    logic [47:0] temp_reg;
    logic [47:0] press_a_reg;
    logic [47:0] press_b_reg;
    logic [47:0] press_c_reg;
    logic [31:0] hum_a_reg;
    logic [31:0] hum_b_reg;

    logic [19:0] raw_reg;
    logic [1:0]  kind_reg;
    logic [31:0] res_reg;
    logic        zero_reg;
    logic [31:0] out_val_reg;
    logic [1:0]  out_kind_reg;
    logic        out_zero_reg;

    logic [63:0] rf [4];
    logic [63:0] rf_a_reg;
    logic [63:0] rf_b_reg;

    pthc_pkg::instr_t ins;
    logic [63:0] opa;
    logic [63:0] opb;
    logic [63:0] alu_res;
    logic [63:0] wb_val;
    logic        rf_we;

    logic        accept;
    logic        out_load;
    logic        mul_start;
    logic        mul_done;
    logic [63:0] mul_p;
    logic        div_start;
    logic        div_done;
    logic [63:0] div_q;

    assign ins    = pthc_pkg::rom(pc_reg);
    assign accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_axis_tready);

    function automatic logic [63:0] pick(input logic [4:0] code, input logic [63:0] rfv);
        logic [63:0] r;
        case (code)
            pthc_pkg::S_R0, pthc_pkg::S_R1,
            pthc_pkg::S_R2, pthc_pkg::S_R3: r = rfv;
            pthc_pkg::S_ADC:   r = {44'd0, raw_reg};
            pthc_pkg::S_ADC16: r = {48'd0, raw_reg[15:0]};
            pthc_pkg::S_FT:    r = pthc_pkg::sext32(ft_reg);
            pthc_pkg::S_IMM:   r = pthc_pkg::sext32(ins.imm);
            pthc_pkg::S_T1:    r = {48'd0, temp_reg[15:0]};
            pthc_pkg::S_T2:    r = {{48{temp_reg[31]}}, temp_reg[31:16]};
            pthc_pkg::S_T3:    r = {{48{temp_reg[47]}}, temp_reg[47:32]};
            pthc_pkg::S_P1:    r = {48'd0, press_a_reg[15:0]};
            pthc_pkg::S_P2:    r = {{48{press_a_reg[31]}}, press_a_reg[31:16]};
            pthc_pkg::S_P3:    r = {{48{press_a_reg[47]}}, press_a_reg[47:32]};
            pthc_pkg::S_P4:    r = {{48{press_b_reg[15]}}, press_b_reg[15:0]};
            pthc_pkg::S_P5:    r = {{48{press_b_reg[31]}}, press_b_reg[31:16]};
            pthc_pkg::S_P6:    r = {{48{press_b_reg[47]}}, press_b_reg[47:32]};
            pthc_pkg::S_P7:    r = {{48{press_c_reg[15]}}, press_c_reg[15:0]};
            pthc_pkg::S_P8:    r = {{48{press_c_reg[31]}}, press_c_reg[31:16]};
            pthc_pkg::S_P9:    r = {{48{press_c_reg[47]}}, press_c_reg[47:32]};
            pthc_pkg::S_H1:    r = {56'd0, hum_a_reg[7:0]};
            pthc_pkg::S_H2:    r = {{48{hum_a_reg[23]}}, hum_a_reg[23:8]};
            pthc_pkg::S_H3:    r = {56'd0, hum_a_reg[31:24]};
            pthc_pkg::S_H4:    r = {52'd0, hum_b_reg[11:0]};
            pthc_pkg::S_H5:    r = {52'd0, hum_b_reg[23:12]};
            pthc_pkg::S_H6:    r = {{56{hum_b_reg[31]}}, hum_b_reg[31:24]};
            default:           r = 64'd0;
        endcase
        return r;
    endfunction

    always_comb
    begin
        opa = pick(ins.a, rf_a_reg);
        opb = pick(ins.b, rf_b_reg);
    end

    always_comb
    begin
        unique case (ins.op)
            pthc_pkg::OP_ADD:   alu_res = opa + opb;
            pthc_pkg::OP_SUB:   alu_res = opa - opb;
            pthc_pkg::OP_SHL:   alu_res = opa << ins.sh;
            pthc_pkg::OP_ASR:   alu_res = $unsigned($signed(opa) >>> ins.sh);
            pthc_pkg::OP_CLAMP:
            begin
                if (opa[63])
                    alu_res = 64'd0;
                else if (opa > pthc_pkg::HUM_MAX)
                    alu_res = pthc_pkg::HUM_MAX;
                else
                    alu_res = opa;
            end
            pthc_pkg::OP_MUL:   alu_res = mul_p;
            pthc_pkg::OP_DIV:   alu_res = div_q;
            default:            alu_res = 64'd0;
        endcase
    end

    assign wb_val = ins.w32 ? pthc_pkg::sext32(alu_res[31:0]) : alu_res;

    always_comb
    begin
        rf_we = 1'b0;
        if (state_reg == ST_EXEC)
        begin
            case (ins.op)
                pthc_pkg::OP_ADD, pthc_pkg::OP_SUB, pthc_pkg::OP_SHL,
                pthc_pkg::OP_ASR, pthc_pkg::OP_CLAMP: rf_we = 1'b1;
                default:                              rf_we = 1'b0;
            endcase
        end
        else if ((state_reg == ST_MUL) && mul_done)
            rf_we = 1'b1;
        else if ((state_reg == ST_DIV) && div_done)
            rf_we = 1'b1;
    end

    assign mul_start = (state_reg == ST_EXEC) && (ins.op == pthc_pkg::OP_MUL);
    assign div_start = (state_reg == ST_EXEC) && (ins.op == pthc_pkg::OP_DIV);

    pthc_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .w32   (ins.w32),
        .a     (opa),
        .b     (opb),
        .done  (mul_done),
        .p     (mul_p)
    );

    pthc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .n     (opa),
        .d     (opb),
        .done  (div_done),
        .q     (div_q)
    );

    // register file: one write, two registered reads
    always_ff @(posedge clk)
    begin
        if (rf_we)
            rf[ins.dst] <= wb_val;
        rf_a_reg <= rf[ins.a[1:0]];
        rf_b_reg <= rf[ins.b[1:0]];
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pc_reg      <= pthc_pkg::PC_TEMP;
            ft_reg      <= 32'd0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
                m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_axis_tready)
                m_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        pc_reg    <= pthc_pkg::start_pc(s_axis_tuser);
                        state_reg <= ST_FETCH;
                    end
                end
                ST_FETCH:
                    state_reg <= ST_EXEC;
                ST_EXEC:
                begin
                    case (ins.op)
                        pthc_pkg::OP_MUL: state_reg <= ST_MUL;
                        pthc_pkg::OP_DIV: state_reg <= ST_DIV;
                        pthc_pkg::OP_END: state_reg <= ST_OUT;
                        pthc_pkg::OP_ZCHK:
                        begin
                            if (opa == 64'd0)
                                state_reg <= ST_OUT;
                            else
                            begin
                                pc_reg    <= pc_reg + 7'd1;
                                state_reg <= ST_FETCH;
                            end
                        end
                        default:
                        begin
                            if (ins.op == pthc_pkg::OP_SETFT)
                                ft_reg <= opa[31:0];
                            pc_reg    <= pc_reg + 7'd1;
                            state_reg <= ST_FETCH;
                        end
                    endcase
                end
                ST_MUL:
                begin
                    if (mul_done)
                    begin
                        pc_reg    <= pc_reg + 7'd1;
                        state_reg <= ST_FETCH;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        pc_reg    <= pc_reg + 7'd1;
                        state_reg <= ST_FETCH;
                    end
                end
                ST_OUT:
                begin
                    if (out_load)
                        state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_reg    <= 48'd0;
            press_a_reg <= 48'd0;
            press_b_reg <= 48'd0;
            press_c_reg <= 48'd0;
            hum_a_reg   <= 32'd0;
            hum_b_reg   <= 32'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pthc_pkg::CFG_TEMP:    temp_reg    <= cfg_data;
                pthc_pkg::CFG_PRESS_A: press_a_reg <= cfg_data;
                pthc_pkg::CFG_PRESS_B: press_b_reg <= cfg_data;
                pthc_pkg::CFG_PRESS_C: press_c_reg <= cfg_data;
                pthc_pkg::CFG_HUM_A:   hum_a_reg   <= cfg_data[31:0];
                pthc_pkg::CFG_HUM_B:   hum_b_reg   <= cfg_data[31:0];
                default:               ;
            endcase
        end
    end

    // item payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            raw_reg  <= s_axis_tdata[19:0];
            kind_reg <= s_axis_tuser;
        end
        if (state_reg == ST_EXEC)
        begin
            if (ins.op == pthc_pkg::OP_END)
            begin
                res_reg  <= opa[31:0];
                zero_reg <= 1'b0;
            end
            else if (ins.op == pthc_pkg::OP_ZCHK)
            begin
                res_reg  <= 32'd0;
                zero_reg <= 1'b1;
            end
        end
        if (out_load)
        begin
            out_val_reg  <= res_reg;
            out_kind_reg <= kind_reg;
            out_zero_reg <= zero_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = out_val_reg;
    assign m_axis_tuser  = {out_zero_reg, out_kind_reg};

    a_zero_only_press: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1:0] == pthc_pkg::FUNC_PRESS)
        else $error("zero divisor flag on a non-pressure result");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_FETCH)
        else $error("accepted item did not start the sequencer");

    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> pc_reg < 7'(pthc_pkg::ROM_DEPTH))
        else $error("program counter out of range");

    a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> state_reg == ST_MUL)
        else $error("multiplier finished outside a multiply");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside a divide");

endmodule

`default_nettype wire
